// ===== design/mdbd_pkg.sv =====
// ----------------------------------------------------------------------------
// mdbd_pkg
// Shared constants and codes of the motion direction break detector.
// ----------------------------------------------------------------------------
package mdbd_pkg;

  // Default sizing of the window store and of the reference span
  localparam int unsigned MAX_SAMPLES_DEF = 256;
  localparam int unsigned REF_FRAMES_DEF  = 5;

  // Serial multiplier digit width, in bits of the multiplier operand per cycle
  localparam int unsigned MUL_DIGIT = 8;

  // Coordinate and configuration widths
  localparam int unsigned XY_W      = 16;
  localparam int unsigned CFG_W     = 30;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MIN_SQ_W  = 30;
  localparam int unsigned COS_W     = 16;
  localparam int unsigned HOLD_W    = 8;
  localparam int unsigned IDX_OUT_W = 8;

  // The cosine threshold is Q1.15, so its square carries 30 fraction bits
  localparam int unsigned COS_SQ_SHIFT = 30;

  localparam logic [HOLD_W-1:0] HOLD_MIN = HOLD_W'(1);

  // Configuration register indices
  localparam logic [CFG_IDX_W-1:0] CFG_HAND     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COS      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd3;

  typedef enum logic [1:0] {
    STAT_BREAK   = 2'd0,
    STAT_NONE    = 2'd1,
    STAT_INVALID = 2'd2,
    STAT_NOREF   = 2'd3
  } status_e;

endpackage

// ===== design/mdbd_mul.sv =====
// ----------------------------------------------------------------------------
// mdbd_mul
// Unsigned digit-serial multiplier: one digit of b per cycle, most
// significant digit first, product held until the next start.
// ----------------------------------------------------------------------------
module mdbd_mul import mdbd_pkg::*; #(
  parameter int unsigned A_W = 32,
  parameter int unsigned B_W = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic               busy_o,
  output logic [A_W+B_W-1:0] p_o
);

  localparam int unsigned NSTEP = (B_W + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int unsigned BP_W  = NSTEP * MUL_DIGIT;
  localparam int unsigned P_W   = A_W + B_W;
  localparam int unsigned S_W   = $clog2(NSTEP + 1);
  localparam int unsigned PP_W  = A_W + MUL_DIGIT;

  logic             busy_q;
  logic [S_W-1:0]   step_q;
  logic [A_W-1:0]   a_q;
  logic [BP_W-1:0]  b_q;
  logic [P_W-1:0]   acc_q;
  logic [P_W-1:0]   acc_d;
  logic [PP_W-1:0]  pp;

  assign pp    = a_q * b_q[BP_W-1 -: MUL_DIGIT];
  assign acc_d = (acc_q << MUL_DIGIT) + P_W'(pp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= S_W'(NSTEP);
    end else if (busy_q) begin
      step_q <= step_q - S_W'(1);
      if (step_q == S_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= BP_W'(b_i);
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= b_q << MUL_DIGIT;
    end
  end

  assign busy_o = busy_q;
  assign p_o    = acc_q;

endmodule

// ===== design/motion_direction_break_detector.sv =====
// ----------------------------------------------------------------------------
// motion_direction_break_detector
// Loads a window of wrist positions into a store with one read port and,
// on the last word, walks it to find the first sustained direction break.
//
//   channel  handshake           payload
//   -------  ------------------  ------------------------------------------
//   input    start, busy         left/right x/y, start_index, last
//   result   done_o (strobe)     status_o, break_index_o, overflow_o
//   config   cfg_we_i            cfg_idx_i, cfg_wdata_i
//
// Back-to-back non-last words load at one per cycle. After the last word
// busy stays high for the walk: each reference frame is read and summed,
// c^2 times the reference square is formed on a serial multiplier, then
// each searched frame is read and tested, with a further wait where the
// cosine compare needs the two serial multipliers (one 8-bit digit a
// cycle). The single read port of the store has the two words of a frame
// read in turn. The result strobe is a single cycle and cannot be held
// off. Reset clears the counters and configuration; the store needs no
// clearing pass, since only words of the current window are read.
// ----------------------------------------------------------------------------
module motion_direction_break_detector import mdbd_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int unsigned REF_FRAMES  = REF_FRAMES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [XY_W-1:0] left_x_i,
  input  logic signed [XY_W-1:0] left_y_i,
  input  logic signed [XY_W-1:0] right_x_i,
  input  logic signed [XY_W-1:0] right_y_i,
  input  logic [7:0]            start_index_i,
  input  logic                  last_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic [IDX_OUT_W-1:0]  break_index_o,
  output logic                  overflow_o
);

  localparam int unsigned AW   = $clog2(MAX_SAMPLES);
  localparam int unsigned CNTW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned IXW  = ((CNTW > 8) ? CNTW : 8) + 1;
  localparam int unsigned DXW  = XY_W + 1;
  localparam int unsigned RW   = DXW + $clog2(REF_FRAMES);
  localparam int unsigned D2W  = 2 * XY_W + 1;
  localparam int unsigned R2W  = 2 * RW - 1;
  localparam int unsigned CSQW = 2 * COS_W - 1;
  localparam int unsigned KW   = CSQW + R2W;
  localparam int unsigned DOTW = RW + DXW;
  localparam int unsigned ADW  = DOTW - 1;
  localparam int unsigned LW   = 2 * ADW;
  localparam int unsigned PW   = KW + D2W;

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_CHECK = 13'b0000000000010,
    ST_RDA   = 13'b0000000000100,
    ST_RDB   = 13'b0000000001000,
    ST_MOVE  = 13'b0000000010000,
    ST_RACC  = 13'b0000000100000,
    ST_RCHK  = 13'b0000001000000,
    ST_KGO   = 13'b0000010000000,
    ST_KWAIT = 13'b0000100000000,
    ST_DOT   = 13'b0001000000000,
    ST_TEST  = 13'b0010000000000,
    ST_CMUL  = 13'b0100000000000,
    ST_SPARE = 13'b1000000000000
  } state_e;

  // Configuration
  logic                    hand_q;
  logic [MIN_SQ_W-1:0]     min_q;
  logic signed [COS_W-1:0] cos_q;
  logic [HOLD_W-1:0]       hold_q;

  // Control
  state_e           state_q, state_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic [AW-1:0]    fi_q, fi_d;
  logic             pass2_q, pass2_d;
  logic             any_q, any_d;
  logic [HOLD_W-1:0] run_q, run_d;
  logic             done_q, done_d;

  // Datapath
  logic [7:0]              start_q, start_d;
  logic [AW-1:0]           end_q, end_d;
  logic [CSQW-1:0]         csq_q, csq_d;
  logic [2*XY_W-1:0]       prev_q, prev_d;
  logic signed [DXW-1:0]   dx_q, dx_d, dy_q, dy_d;
  logic signed [RW-1:0]    rx_q, rx_d, ry_q, ry_d;
  logic [R2W-1:0]          r2_q, r2_d;
  logic [KW-1:0]           k_q, k_d;
  logic [D2W-1:0]          d2_q, d2_d;
  logic signed [DOTW-1:0]  dot_q, dot_d;
  status_e                 stat_q, stat_d;
  logic [IDX_OUT_W-1:0]    bidx_q, bidx_d;
  logic                    ovfo_q, ovfo_d;

  // Window store
  logic [2*XY_W-1:0] mem [MAX_SAMPLES];
  logic [2*XY_W-1:0] rdata_q;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [2*XY_W-1:0] wr_data;

  // Multipliers
  logic           mula_start, mula_busy;
  logic [KW-1:0]  mula_a;
  logic [D2W-1:0] mula_b;
  logic [PW-1:0]  mula_p;
  logic           mulb_start, mulb_busy;
  logic [ADW-1:0] mulb_a;
  logic [LW-1:0]  mulb_p;

  // Combinational helpers
  logic                    accept;
  logic                    room;
  logic signed [XY_W-1:0]  cur_x, cur_y, prv_x, prv_y;
  logic signed [2*DXW-1:0] sqx, sqy;
  logic [D2W-1:0]          d2_c;
  logic                    fast_c, fast_q;
  logic signed [DOTW-1:0]  dxe, dye, rxe, rye, dot_c;
  logic signed [2*RW-1:0]  sqrx, sqry;
  logic [R2W-1:0]          r2_c;
  logic [ADW-1:0]          adot;
  logic                    cneg, dot_le0, dot_ge0;
  logic [PW-1:0]           lhs, rhs;
  logic [IXW-1:0]          nx, sx, ex, lim;
  logic                    invalid;
  logic [AW-1:0]           last_fi;
  logic [HOLD_W-1:0]       hold_eff;
  logic [HOLD_W:0]         run_inc;
  logic                    fr_done, fr_turn;
  logic [CSQW*2-1:0]       csq_full;

  assign accept = start && !busy;
  assign room   = cnt_q < CNTW'(MAX_SAMPLES);

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hand_q <= 1'b1;
      min_q  <= '0;
      cos_q  <= '0;
      hold_q <= HOLD_MIN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HAND:     hand_q <= cfg_wdata_i[0];
        CFG_MIN_STEP: min_q  <= cfg_wdata_i[MIN_SQ_W-1:0];
        CFG_COS:      cos_q  <= cfg_wdata_i[COS_W-1:0];
        CFG_HOLD:     hold_q <= cfg_wdata_i[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // ----------------------------------------------------------------- store
  assign wr_en   = accept && room;
  assign wr_data = hand_q ? {right_y_i, right_x_i} : {left_y_i, left_x_i};
  assign rd_addr = (state_q == ST_RDA) ? fi_q - AW'(1) : fi_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[AW-1:0]] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  // ------------------------------------------------------------- datapath
  assign cur_x = rdata_q[XY_W-1:0];
  assign cur_y = rdata_q[2*XY_W-1:XY_W];
  assign prv_x = prev_q[XY_W-1:0];
  assign prv_y = prev_q[2*XY_W-1:XY_W];

  assign sqx    = dx_q * dx_q;
  assign sqy    = dy_q * dy_q;
  assign d2_c   = sqx[D2W-1:0] + sqy[D2W-1:0];
  assign fast_c = d2_c >= D2W'(min_q);
  assign fast_q = d2_q >= D2W'(min_q);

  assign dxe   = DOTW'(dx_q);
  assign dye   = DOTW'(dy_q);
  assign rxe   = DOTW'(rx_q);
  assign rye   = DOTW'(ry_q);
  assign dot_c = dxe * rxe + dye * rye;

  assign sqrx = rx_q * rx_q;
  assign sqry = ry_q * ry_q;
  assign r2_c = sqrx[R2W-1:0] + sqry[R2W-1:0];

  assign adot    = dot_q[DOTW-1] ? ADW'(-dot_q) : ADW'(dot_q);
  assign cneg    = cos_q[COS_W-1];
  assign dot_le0 = dot_q[DOTW-1] || (dot_q == '0);
  assign dot_ge0 = !dot_q[DOTW-1];

  assign lhs = PW'(mulb_p) << COS_SQ_SHIFT;
  assign rhs = mula_p;

  assign csq_full = cos_q * cos_q;

  assign nx      = IXW'(cnt_q);
  assign sx      = IXW'(start_q);
  assign lim     = nx - IXW'(1);
  assign ex      = sx + IXW'(REF_FRAMES - 1);
  assign invalid = (nx < IXW'(2)) || (sx == '0) || (sx >= lim);
  assign last_fi = AW'(cnt_q - CNTW'(1));

  assign hold_eff = (hold_q == '0) ? HOLD_MIN : hold_q;
  assign run_inc  = {1'b0, run_q} + (HOLD_W+1)'(1);

  // Serial multipliers: unit a forms c^2*|r|^2 once, then that times |d|^2
  assign mula_start = (state_q == ST_KGO) || (state_q == ST_TEST && fr_done == 1'b0 &&
                      fast_q && !(!cneg && dot_le0) && !(cneg && dot_ge0));
  assign mulb_start = (state_q == ST_TEST) && mula_start;
  assign mula_a     = (state_q == ST_KGO) ? KW'(r2_q) : k_q;
  assign mula_b     = (state_q == ST_KGO) ? D2W'(csq_q) : d2_q;
  assign mulb_a     = adot;

  mdbd_mul #(
    .A_W (KW),
    .B_W (D2W)
  ) u_mul_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mula_start),
    .a_i     (mula_a),
    .b_i     (mula_b),
    .busy_o  (mula_busy),
    .p_o     (mula_p)
  );

  mdbd_mul #(
    .A_W (ADW),
    .B_W (ADW)
  ) u_mul_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mulb_start),
    .a_i     (mulb_a),
    .b_i     (mulb_a),
    .busy_o  (mulb_busy),
    .p_o     (mulb_p)
  );

  // Outcome of one searched frame: slow frames count as not turned
  always_comb begin
    fr_done = 1'b0;
    fr_turn = 1'b0;
    if (state_q == ST_TEST) begin
      if (!fast_q) begin
        fr_done = 1'b1;
      end else if (!cneg && dot_le0) begin
        fr_done = 1'b1;
        fr_turn = 1'b1;
      end else if (cneg && dot_ge0) begin
        fr_done = 1'b1;
      end
    end else if (state_q == ST_CMUL && !mula_busy && !mulb_busy) begin
      fr_done = 1'b1;
      fr_turn = cneg ? !(rhs > lhs) : !(lhs > rhs);
    end
  end

  // ------------------------------------------------------------ sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    fi_d    = fi_q;
    pass2_d = pass2_q;
    any_d   = any_q;
    run_d   = run_q;
    done_d  = 1'b0;
    start_d = start_q;
    end_d   = end_q;
    csq_d   = csq_q;
    prev_d  = prev_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    rx_d    = rx_q;
    ry_d    = ry_q;
    r2_d    = r2_q;
    k_d     = k_q;
    d2_d    = d2_q;
    dot_d   = dot_q;
    stat_d  = stat_q;
    bidx_d  = bidx_q;
    ovfo_d  = ovfo_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (room) begin
            cnt_d = cnt_q + CNTW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_i) begin
            start_d = start_index_i;
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (invalid) begin
          done_d  = 1'b1;
          stat_d  = STAT_INVALID;
          bidx_d  = '0;
          ovfo_d  = ovf_q;
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end else begin
          fi_d    = AW'(sx);
          end_d   = AW'((ex > lim) ? lim : ex);
          csq_d   = csq_full[CSQW-1:0];
          rx_d    = '0;
          ry_d    = '0;
          any_d   = 1'b0;
          pass2_d = 1'b0;
          state_d = ST_RDA;
        end
      end
      ST_RDA: begin
        state_d = ST_RDB;
      end
      ST_RDB: begin
        prev_d  = rdata_q;
        state_d = ST_MOVE;
      end
      ST_MOVE: begin
        dx_d    = DXW'(cur_x) - DXW'(prv_x);
        dy_d    = DXW'(cur_y) - DXW'(prv_y);
        state_d = pass2_q ? ST_DOT : ST_RACC;
      end
      ST_RACC: begin
        if (fast_c) begin
          rx_d  = rx_q + RW'(dx_q);
          ry_d  = ry_q + RW'(dy_q);
          any_d = 1'b1;
        end
        if (fi_q == end_q) begin
          state_d = ST_RCHK;
        end else begin
          fi_d    = fi_q + AW'(1);
          state_d = ST_RDA;
        end
      end
      ST_RCHK: begin
        if (!any_q || (rx_q == '0 && ry_q == '0)) begin
          done_d  = 1'b1;
          stat_d  = STAT_NOREF;
          bidx_d  = '0;
          ovfo_d  = ovf_q;
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end else begin
          r2_d    = r2_c;
          state_d = ST_KGO;
        end
      end
      ST_KGO: begin
        state_d = ST_KWAIT;
      end
      ST_KWAIT: begin
        if (!mula_busy) begin
          k_d     = mula_p[KW-1:0];
          fi_d    = AW'(sx + IXW'(1));
          run_d   = '0;
          pass2_d = 1'b1;
          state_d = ST_RDA;
        end
      end
      ST_DOT: begin
        d2_d    = d2_c;
        dot_d   = dot_c;
        state_d = ST_TEST;
      end
      ST_TEST, ST_CMUL: begin
        if (!fr_done) begin
          state_d = ST_CMUL;
        end else if (fr_turn && (run_inc >= {1'b0, hold_eff})) begin
          done_d  = 1'b1;
          stat_d  = STAT_BREAK;
          bidx_d  = IDX_OUT_W'(fi_q);
          ovfo_d  = ovf_q;
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end else begin
          run_d = fr_turn ? run_inc[HOLD_W-1:0] : '0;
          if (fi_q == last_fi) begin
            done_d  = 1'b1;
            stat_d  = STAT_NONE;
            bidx_d  = '0;
            ovfo_d  = ovf_q;
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            fi_d    = fi_q + AW'(1);
            state_d = ST_RDA;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      fi_q    <= '0;
      pass2_q <= 1'b0;
      any_q   <= 1'b0;
      run_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      fi_q    <= fi_d;
      pass2_q <= pass2_d;
      any_q   <= any_d;
      run_q   <= run_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    end_q   <= end_d;
    csq_q   <= csq_d;
    prev_q  <= prev_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    rx_q    <= rx_d;
    ry_q    <= ry_d;
    r2_q    <= r2_d;
    k_q     <= k_d;
    d2_q    <= d2_d;
    dot_q   <= dot_d;
    stat_q  <= stat_d;
    bidx_q  <= bidx_d;
    ovfo_q  <= ovfo_d;
  end

  assign busy          = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign status_o      = stat_q;
  assign break_index_o = bidx_q;
  assign overflow_o    = ovfo_q;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the motion direction break detector. Windows of
// wrist tracks are loaded word by word with random gaps. Each window is
// scored by a bit-exact predictor in the break_tracker class. Registers are
// retuned between windows, and one window once switches hand part way.
// ----------------------------------------------------------------------------
module tb_top;
  import mdbd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e        status;
    logic [7:0]     index;
    logic           overflow;
  } verdict_t;

  // Predictor of the walk plus the queue of verdicts still to arrive
  class break_tracker;
    bit [31:0]          track [MAX_SAMPLES_DEF];
    int unsigned        stored = 0;
    bit                 dropped = 1'b0;
    bit                 hand = 1'b1;
    bit [MIN_SQ_W-1:0]  min_sq = '0;
    logic signed [15:0] cos_thr = '0;
    bit [HOLD_W-1:0]    hold = HOLD_MIN;
    verdict_t           verdicts_due [$];
    int unsigned        mismatches = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_HAND:     hand = val[0];
        CFG_MIN_STEP: min_sq = val[MIN_SQ_W-1:0];
        CFG_COS:      cos_thr = val[COS_W-1:0];
        CFG_HOLD:     hold = val[HOLD_W-1:0];
        default:      ;
      endcase
    endfunction

    function void frame_move(int unsigned i, output longint dx, output longint dy);
      dx = longint'($signed(track[i][15:0])) - longint'($signed(track[i-1][15:0]));
      dy = longint'($signed(track[i][31:16])) - longint'($signed(track[i-1][31:16]));
    endfunction

    // Compare squared terms: 2^30 * dot^2 against c^2 * |d|^2 * |r|^2
    function bit is_turned(longint dx, longint dy, longint rx, longint ry);
      longint     dot;
      longint     c;
      bit [127:0] ad, dd, rr, cc, lhs, rhs;
      dot = dx * rx + dy * ry;
      c = longint'(cos_thr);
      if (c >= 0 && dot <= 0) return 1'b1;
      if (c < 0 && dot >= 0) return 1'b0;
      ad = 128'((dot < 0) ? -dot : dot);
      dd = 128'(dx * dx + dy * dy);
      rr = 128'(rx * rx + ry * ry);
      cc = 128'(c * c);
      lhs = (ad * ad) << COS_SQ_SHIFT;
      rhs = cc * dd * rr;
      return (c >= 0) ? (lhs <= rhs) : (rhs <= lhs);
    endfunction

    function status_e walk(int unsigned first, output logic [7:0] at);
      int unsigned n, ref_end, need, run, fast, i;
      longint      dx, dy, rx, ry;
      at = '0;
      n = stored;
      need = (hold == '0) ? 1 : int'(hold);
      if (n < 2 || first < 1 || first >= n - 1) return STAT_INVALID;
      ref_end = first + REF_FRAMES_DEF - 1;
      if (ref_end > n - 1) ref_end = n - 1;
      rx = 0;
      ry = 0;
      fast = 0;
      for (i = first; i <= ref_end; i++) begin
        frame_move(i, dx, dy);
        if (dx * dx + dy * dy >= longint'(min_sq)) begin
          rx += dx;
          ry += dy;
          fast++;
        end
      end
      if (fast == 0 || (rx == 0 && ry == 0)) return STAT_NOREF;
      run = 0;
      for (i = first + 1; i < n; i++) begin
        frame_move(i, dx, dy);
        if (dx * dx + dy * dy < longint'(min_sq)) begin
          run = 0;
        end else if (is_turned(dx, dy, rx, ry)) begin
          run++;
          if (run >= need) begin
            at = 8'(i);
            return STAT_BREAK;
          end
        end else begin
          run = 0;
        end
      end
      return STAT_NONE;
    endfunction

    function void take_sample(logic [15:0] lx, logic [15:0] ly, logic [15:0] rx,
                              logic [15:0] ry, logic [7:0] sidx, logic is_last);
      verdict_t   v;
      logic [7:0] at;
      if (stored < MAX_SAMPLES_DEF) begin
        track[stored] = hand ? {ry, rx} : {ly, lx};
        stored++;
      end else begin
        dropped = 1'b1;
      end
      if (!is_last) return;
      v.status = walk(int'(sidx), at);
      v.index = at;
      v.overflow = dropped;
      verdicts_due.push_back(v);
      stored = 0;
      dropped = 1'b0;
    endfunction

    function void complain(string what, int want, logic [7:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void compare_verdict(logic [1:0] st, logic [7:0] idx, logic ovf);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none expected, status %0d index %0d overflow %0d",
                 $time, st, idx, ovf);
        return;
      end
      want = verdicts_due.pop_front();
      if (st !== want.status) complain("status", int'(want.status), 8'(st));
      if (idx !== want.index) complain("break_index", int'(want.index), idx);
      if (ovf !== want.overflow) complain("overflow", int'(want.overflow), 8'(ovf));
    endfunction

    function int unsigned waiting();
      return verdicts_due.size();
    endfunction
  endclass

  localparam int unsigned SETTLE = 8;
  localparam logic [15:0] XY_MIN = 16'h8000;
  localparam logic [15:0] XY_MAX = 16'h7FFF;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic signed [XY_W-1:0] left_x = '0;
  logic signed [XY_W-1:0] left_y = '0;
  logic signed [XY_W-1:0] right_x = '0;
  logic signed [XY_W-1:0] right_y = '0;
  logic [7:0]            start_index = '0;
  logic                  last_word = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  done_o;
  logic [1:0]            status_o;
  logic [IDX_OUT_W-1:0]  break_index_o;
  logic                  overflow_o;

  break_tracker tracker;
  bit           burst = 1'b0;
  bit           hand_now = 1'b1;
  int unsigned  samples_sent = 0;
  int unsigned  window_no = 0;

  motion_direction_break_detector u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .left_x_i      (left_x),
    .left_y_i      (left_y),
    .right_x_i     (right_x),
    .right_y_i     (right_y),
    .start_index_i (start_index),
    .last_i        (last_word),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .done_o        (done_o),
    .status_o      (status_o),
    .break_index_o (break_index_o),
    .overflow_o    (overflow_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) tracker.compare_verdict(status_o, break_index_o, overflow_o);
  end

  function automatic int spread(int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Leaves start high after the word is taken, so a following word can
  // go out back to back
  task automatic push_sample(logic [15:0] lx, logic [15:0] ly, logic [15:0] rx,
                             logic [15:0] ry, logic [7:0] sidx, logic is_last);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    left_x <= lx;
    left_y <= ly;
    right_x <= rx;
    right_y <= ry;
    start_index <= sidx;
    last_word <= is_last;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    tracker.take_sample(lx, ly, rx, ry, sidx, is_last);
    samples_sent++;
  endtask

  // Put the track on the hand in use and noise on the other
  task automatic push_track(int x, int y, logic [7:0] sidx, logic is_last);
    logic [15:0] ox, oy;
    ox = 16'($urandom);
    oy = 16'($urandom);
    if (hand_now) push_sample(ox, oy, 16'(x), 16'(y), sidx, is_last);
    else push_sample(16'(x), 16'(y), ox, oy, sidx, is_last);
  endtask

  task automatic hold_off();
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic drain();
    hold_off();
    while (tracker.waiting() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain();
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    tracker.set_reg(idx, val);
    if (idx == CFG_HAND) hand_now = val[0];
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic retune();
    logic [15:0] cv;
    if ($urandom_range(0, 1) == 1) write_reg(CFG_HAND, CFG_W'($urandom_range(0, 1)));
    case ($urandom_range(0, 5))
      0:       write_reg(CFG_MIN_STEP, '0);
      1:       write_reg(CFG_MIN_STEP, 30'h3FFF_FFFF);
      2:       write_reg(CFG_MIN_STEP, CFG_W'($urandom_range(0, 600)));
      3:       write_reg(CFG_MIN_STEP, CFG_W'($urandom_range(0, 60000)));
      4:       write_reg(CFG_MIN_STEP, CFG_W'($urandom_range(0, 250000)));
      default: write_reg(CFG_MIN_STEP, CFG_W'($urandom));
    endcase
    case ($urandom_range(0, 6))
      0:       cv = 16'h8000;
      1:       cv = 16'h7FFF;
      2:       cv = 16'h0000;
      3:       cv = 16'h4000;
      4:       cv = 16'hC000;
      5:       cv = 16'h5A82;
      default: cv = 16'($urandom);
    endcase
    write_reg(CFG_COS, {14'd0, cv});
    case ($urandom_range(0, 9))
      0, 1, 2, 3: write_reg(CFG_HOLD, CFG_W'(1));
      4, 5:       write_reg(CFG_HOLD, CFG_W'($urandom_range(2, 4)));
      6:          write_reg(CFG_HOLD, CFG_W'($urandom_range(5, 20)));
      7:          write_reg(CFG_HOLD, CFG_W'(255));
      8:          write_reg(CFG_HOLD, '0);
      default:    write_reg(CFG_HOLD, CFG_W'($urandom_range(1, 255)));
    endcase
  endtask

  task automatic noise_window(int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++)
      push_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  8'($urandom), k == n - 1);
  endtask

  // Steady motion up to the turn frame, from it on a reversed, perpendicular,
  // unchanged or random motion, with jitter and the odd frame standing still
  task automatic play_window(int unsigned n, int unsigned first, int unsigned turn,
                             int unsigned bend);
    int          px, py, vx, vy, wx, wy, sx, sy, span, jit;
    int unsigned k;
    span = ($urandom_range(0, 3) == 0) ? 24 : 400;
    jit = span / 24;
    px = spread(4000);
    py = spread(4000);
    vx = spread(span);
    vy = spread(span);
    case (bend)
      0: begin
        wx = -vx;
        wy = -vy;
      end
      1: begin
        wx = -vy;
        wy = vx;
      end
      2: begin
        wx = vx;
        wy = vy;
      end
      default: begin
        wx = spread(span);
        wy = spread(span);
      end
    endcase
    for (k = 0; k < n; k++) begin
      if (k > 0) begin
        sx = (k < turn) ? vx : wx;
        sy = (k < turn) ? vy : wy;
        sx += spread(jit);
        sy += spread(jit);
        if ($urandom_range(0, 11) == 0) begin
          sx = 0;
          sy = 0;
        end
        px += sx;
        py += sy;
      end
      push_track(px, py, (k == n - 1) ? 8'(first) : 8'($urandom), k == n - 1);
    end
  endtask

  task automatic random_window();
    int unsigned n, first, pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      noise_window($urandom_range(1, 8));
      return;
    end
    n = (pick == 1) ? $urandom_range(25, 60) : $urandom_range(2, 20);
    if (n < 3 || $urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0:       first = 0;
        1:       first = n - 1;
        default: first = $urandom_range(0, 255);
      endcase
    end else begin
      first = $urandom_range(1, n - 2);
    end
    play_window(n, first, first + $urandom_range(1, 10), $urandom_range(0, 3));
  endtask

  task automatic directed_checks();
    // single word: too short
    push_sample(XY_MIN, XY_MAX, XY_MAX, XY_MIN, 8'd0, 1'b1);
    // full-scale swings on both hands, break where the move turns square
    push_sample(XY_MAX, XY_MAX, XY_MIN, XY_MIN, 8'hFF, 1'b0);
    push_sample(XY_MIN, XY_MIN, XY_MAX, XY_MAX, 8'h00, 1'b0);
    push_sample(XY_MAX, XY_MIN, XY_MIN, XY_MAX, 8'd1, 1'b1);
    // start on the last move
    push_track(0, 0, 8'd0, 1'b0);
    push_track(16, 16, 8'd1, 1'b1);
    // reference moves cancel out
    push_track(0, 0, 8'd0, 1'b0);
    push_track(16, 0, 8'd0, 1'b0);
    push_track(0, 0, 8'd1, 1'b1);
    // swap hand part way; the still frame counts as turned
    write_reg(CFG_HAND, '0);
    push_sample(16'd0, 16'd0, 16'd777, 16'd777, 8'd0, 1'b0);
    push_sample(16'd160, 16'd0, 16'hFFFB, 16'hFFFB, 8'd0, 1'b0);
    write_reg(CFG_HAND, CFG_W'(1));
    push_sample(16'd999, 16'd999, 16'd160, 16'd0, 8'd1, 1'b1);
    // zero hold with the threshold at minus one: only a full reversal breaks
    write_reg(CFG_HOLD, '0);
    write_reg(CFG_COS, {14'd0, 16'h8000});
    push_track(0, 0, 8'd0, 1'b0);
    push_track(10, 0, 8'd0, 1'b0);
    push_track(20, 0, 8'd0, 1'b0);
    push_track(10, 0, 8'd0, 1'b0);
    push_track(20, 0, 8'd1, 1'b1);
    // nothing fast enough for a reference
    write_reg(CFG_MIN_STEP, 30'h3FFF_FFFF);
    write_reg(CFG_COS, {14'd0, 16'h7FFF});
    push_track(0, 0, 8'd0, 1'b0);
    push_track(16, 0, 8'd0, 1'b0);
    push_track(48, 16, 8'd1, 1'b1);
    // straight line against a threshold just below one
    write_reg(CFG_MIN_STEP, '0);
    push_track(0, 0, 8'd0, 1'b0);
    push_track(16, 8, 8'd0, 1'b0);
    push_track(32, 16, 8'd0, 1'b0);
    push_track(48, 24, 8'd1, 1'b1);
  endtask

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    tracker = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    directed_checks();
    retune();
    while (samples_sent < 1050) begin
      window_no++;
      burst = ($urandom_range(0, 3) == 0);
      if (window_no == 12) begin
        // overfill the store, search near its end with the turn on its last entry
        write_reg(CFG_HOLD, CFG_W'(1));
        write_reg(CFG_COS, '0);
        write_reg(CFG_MIN_STEP, '0);
        play_window(MAX_SAMPLES_DEF + $urandom_range(1, 6), 250, 255, 0);
      end else if (window_no == 45) begin
        play_window(MAX_SAMPLES_DEF + $urandom_range(0, 6), $urandom_range(1, 250),
                    $urandom_range(1, 255), $urandom_range(0, 3));
      end else begin
        if ($urandom_range(0, 7) == 0) retune();
        else if ($urandom_range(0, 9) == 0) drain();
        random_window();
      end
    end
    hold_off();
    while (tracker.waiting() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/mdbd_pkg.sv
design/mdbd_mul.sv
design/motion_direction_break_detector.sv
tb/tb_top.sv
